// ===== src/qkv_pkg.sv =====
// Shared types and constants for the query key/value extractor.
// Depends on nothing; the design modules and the testbench import it.
`default_nettype none

package qkv_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // tracker code once key and '=' have both matched
  localparam logic [3:0] CONFIRMED = 4'd15;
  localparam logic [5:0] COUNT_CAP = 6'd32;

  localparam logic [1:0] REG_KEY_BYTES   = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [1:0] REG_MAX_VAL_LEN = 2'd2;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_STOPPED,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NOT_FOUND,
    CMD_EMPTY,
    CMD_VALUE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  typedef struct packed {
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [5:0]  max_value_length;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] len;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [7:0] data;
  } wr_t;

  typedef struct packed {
    logic       found;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic [4:0] run_length;
    logic       last_of_run;
  } res_t;

  // advance one key tracker by one byte: 0 idle, m+1 after m key bytes
  function automatic logic [3:0] track(input logic [3:0] code, input logic [7:0] b,
                                       input logic [3:0] klen, input logic [63:0] key);
    logic [3:0] m;
    logic [3:0] r;
    m = code - 4'd1;
    r = 4'd0;
    if (code != 4'd0) begin
      if (m < klen) begin
        if (key[{m[2:0], 3'b000} +: 8] == b) r = code + 4'd1;
      end else if (m == klen) begin
        if (b == CH_EQ) r = CONFIRMED;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/qkv_if.sv =====
// Stream interfaces for the query key/value extractor: input bytes and results.
// Depends on nothing.
`default_nettype none

interface qkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_source;
  modport source(output valid, output data_byte, output end_of_source, input ready);
  modport sink(input valid, input data_byte, input end_of_source, output ready);
endinterface

interface qkv_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic [4:0] run_length;
  logic       last_of_run;
  modport source(output valid, output found, output value_byte, output byte_valid,
                 output run_length, output last_of_run, input ready);
  modport sink(input valid, input found, input value_byte, input byte_valid,
               input run_length, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/query_key_value_extractor.sv =====
// Query key/value extractor. Input: one byte per cycle while scanning; input is held
// while a value run drains and when the command queue is full.
// Results: a not-found or empty result passes the command queue, then the output register;
// each value word passes a store read, then the output register, one word at a time as
// the result side accepts it. Synchronous reset clears control state and configuration;
// the value store is not cleared.
`default_nettype none

module query_key_value_extractor #(
  parameter int MAX_VALUE = 32,
  parameter int MAX_KEY   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  qkv_in_if.sink      rx,
  qkv_out_if.source   tx
);
  import qkv_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic cmd_push;
  logic run_done;
  cmd_t cmd;
  cmd_t q_data;
  wr_t  wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_bytes        <= 64'd0;
      cfg.key_length       <= 4'd0;
      cfg.max_value_length <= 6'd32;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_KEY_BYTES:   cfg.key_bytes        <= cfg_data;
        REG_KEY_LENGTH:  cfg.key_length       <= cfg_data[3:0];
        REG_MAX_VAL_LEN: cfg.max_value_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  qkv_front #(.MAX_VALUE(MAX_VALUE), .MAX_KEY(MAX_KEY)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg      (cfg),
    .q_full   (q_full),
    .run_done (run_done),
    .cmd_push (cmd_push),
    .cmd      (cmd),
    .wr       (wr)
  );

  qkv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  qkv_back #(.MAX_VALUE(MAX_VALUE)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .wr       (wr),
    .run_done (run_done),
    .tx       (tx)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full) else $error("command pushed into full queue");

  a_run_words: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && !tx.last_of_run) |-> (tx.found && tx.byte_valid))
    else $error("non-final word outside a value run");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && !tx.found) |-> (!tx.byte_valid && (tx.run_length == 5'd0) &&
                                 tx.last_of_run))
    else $error("malformed not-found word");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    run_done |-> (tx.valid && tx.ready && tx.last_of_run))
    else $error("value run closed before its last word");
`endif

endmodule

`default_nettype wire

// ===== src/qkv_front.sv =====
// Front end: accepts query bytes, tracks key matches, buffers value bytes.
// Depends on qkv_pkg and qkv_in_if; issues commands to the queue.
`default_nettype none

module qkv_front #(
  parameter int MAX_VALUE = 32,
  parameter int MAX_KEY   = 8
) (
  input  logic          clk,
  input  logic          rst,
  qkv_in_if.sink        rx,
  input  qkv_pkg::cfg_t cfg,
  input  logic          q_full,
  input  logic          run_done,
  output logic          cmd_push,
  output qkv_pkg::cmd_t cmd,
  output qkv_pkg::wr_t  wr
);
  import qkv_pkg::*;

  localparam int DEPTH = (MAX_VALUE < 32) ? MAX_VALUE : 32;
  localparam logic [5:0] DEPTH6 = 6'(DEPTH);

  phase_t     phase, phase_next;
  logic [1:0] flag, flag_next;
  logic [7:0] prev, prev_next;
  logic [3:0] trk_a, trk_a_next;
  logic [3:0] trk_b, trk_b_next;
  logic [5:0] count, count_next;
  logic       lock, lock_next;

  logic       accept;
  logic [7:0] b;
  logic       eos;
  logic       term;
  logic [3:0] kcap;
  logic [3:0] klen;
  logic [5:0] cap;
  logic [3:0] a1, b1, c1;
  logic       hit;
  phase_t     stop;

  function automatic cmd_t value_cmd(input logic [5:0] n, input logic [5:0] lim);
    cmd_t r;
    r.kind = CMD_VALUE;
    r.len  = n[4:0];
    if (n >= lim) begin
      r.kind = CMD_NOT_FOUND;
      r.len  = 5'd0;
    end else if (n == 6'd0) begin
      r.kind = CMD_EMPTY;
    end
    return r;
  endfunction

  assign rx.ready = !lock && !q_full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.data_byte;
  assign eos      = rx.end_of_source;
  assign term     = (b == 8'd0) || (b == CH_SPACE) || (b == CH_NL);

  // effective key length: capped, cut at the first zero byte
  always_comb begin
    kcap = (cfg.key_length > 4'(MAX_KEY)) ? 4'(MAX_KEY) : cfg.key_length;
    klen = kcap;
    for (int i = 7; i >= 0; i--) begin
      if ((4'(i) < kcap) && (cfg.key_bytes[8*i +: 8] == 8'd0)) klen = 4'(i);
    end
    cap = (cfg.max_value_length > DEPTH6) ? DEPTH6 : cfg.max_value_length;
  end

  always_comb begin
    phase_next = phase;
    flag_next  = flag;
    prev_next  = prev;
    trk_a_next = trk_a;
    trk_b_next = trk_b;
    count_next = count;
    cmd_push   = 1'b0;
    cmd        = '{kind: CMD_NOT_FOUND, len: 5'd0};
    wr         = '0;
    a1         = 4'd0;
    b1         = 4'd0;
    c1         = 4'd0;
    hit        = 1'b0;
    stop       = phase;
    if (accept) begin
      unique case (phase) inside
        PH_VALUE: begin
          if (term || (b == CH_AMP)) begin
            cmd_push   = 1'b1;
            cmd        = value_cmd(count, cap);
            phase_next = PH_DONE;
          end else begin
            if (count < DEPTH6) begin
              wr.en   = 1'b1;
              wr.addr = count[4:0];
              wr.data = b;
            end
            if (count < COUNT_CAP) count_next = count + 6'd1;
            if (eos) begin
              cmd_push   = 1'b1;
              cmd        = value_cmd(count_next, cap);
              phase_next = PH_DONE;
            end
          end
        end
        PH_SEARCH, PH_STOPPED: begin
          a1  = track(trk_a, b, klen, cfg.key_bytes);
          b1  = track(trk_b, b, klen, cfg.key_bytes);
          hit = (a1 == CONFIRMED) || (b1 == CONFIRMED);
          if (!hit && (phase == PH_SEARCH)) begin
            if (term) begin
              stop = PH_STOPPED;
            end else if ((flag == 2'd0) || (prev == CH_AMP) ||
                         ((flag == 2'd1) && (prev == CH_QMARK))) begin
              c1 = track(4'd1, b, klen, cfg.key_bytes);
              if (c1 == CONFIRMED) begin
                hit = 1'b1;
              end else if (c1 != 4'd0) begin
                // drop the start when both trackers are busy
                if (a1 == 4'd0) a1 = c1;
                else if (b1 == 4'd0) b1 = c1;
              end
            end
          end
          if (hit) begin
            trk_a_next = 4'd0;
            trk_b_next = 4'd0;
            count_next = 6'd0;
            phase_next = PH_VALUE;
            if (eos) begin
              cmd_push   = 1'b1;
              cmd        = value_cmd(6'd0, cap);
              phase_next = PH_DONE;
            end
          end else begin
            trk_a_next = a1;
            trk_b_next = b1;
            phase_next = stop;
            if (eos || ((stop == PH_STOPPED) && (a1 == 4'd0) && (b1 == 4'd0))) begin
              cmd_push   = 1'b1;
              phase_next = PH_DONE;
            end
          end
        end
        default: ;
      endcase
      prev_next = b;
      if (flag < 2'd2) flag_next = flag + 2'd1;
      if (eos) begin
        phase_next = PH_SEARCH;
        flag_next  = 2'd0;
        prev_next  = 8'd0;
        trk_a_next = 4'd0;
        trk_b_next = 4'd0;
        count_next = 6'd0;
      end
    end
    // hold input while the value store is being drained
    lock_next = (lock && !run_done) || (cmd_push && (cmd.kind == CMD_VALUE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      flag  <= 2'd0;
      prev  <= 8'd0;
      trk_a <= 4'd0;
      trk_b <= 4'd0;
      count <= 6'd0;
      lock  <= 1'b0;
    end else begin
      phase <= phase_next;
      flag  <= flag_next;
      prev  <= prev_next;
      trk_a <= trk_a_next;
      trk_b <= trk_b_next;
      count <= count_next;
      lock  <= lock_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/qkv_queue.sv =====
// Two-entry command queue between the front end and the result back end.
// Depends on qkv_pkg.
`default_nettype none

module qkv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qkv_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output qkv_pkg::cmd_t pop_data
);
  import qkv_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== src/qkv_back.sv =====
// Back end: value store and result sequencer that drains commands as words.
// Depends on qkv_pkg and qkv_out_if.
`default_nettype none

module qkv_back #(
  parameter int MAX_VALUE = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  qkv_pkg::cmd_t q_data,
  output logic          q_pop,
  input  qkv_pkg::wr_t  wr,
  output logic          run_done,
  qkv_out_if.source     tx
);
  import qkv_pkg::*;

  localparam int DEPTH = (MAX_VALUE < 32) ? MAX_VALUE : 32;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  back_state_t state, state_next;
  logic [4:0]  idx, idx_next;
  logic [4:0]  len, len_next;
  logic        is_value, is_value_next;
  res_t        res, res_next;
  logic [4:0]  idx_inc;
  logic        at_last;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign idx_inc = idx + 5'd1;
  assign at_last = (idx == 5'(len - 5'd1));

  assign tx.valid       = (state == BK_SEND);
  assign tx.found       = res.found;
  assign tx.value_byte  = res.value_byte;
  assign tx.byte_valid  = res.byte_valid;
  assign tx.run_length  = res.run_length;
  assign tx.last_of_run = res.last_of_run;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    len_next      = len;
    is_value_next = is_value;
    res_next      = res;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx[AW-1:0];
    run_done      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            CMD_VALUE: begin
              len_next      = q_data.len;
              idx_next      = 5'd0;
              rd_en         = 1'b1;
              rd_addr       = '0;
              is_value_next = 1'b1;
              state_next    = BK_READ;
            end
            CMD_EMPTY: begin
              res_next      = '{found: 1'b1, value_byte: 8'd0, byte_valid: 1'b0,
                                run_length: 5'd0, last_of_run: 1'b1};
              is_value_next = 1'b0;
              state_next    = BK_SEND;
            end
            default: begin
              res_next      = '{found: 1'b0, value_byte: 8'd0, byte_valid: 1'b0,
                                run_length: 5'd0, last_of_run: 1'b1};
              is_value_next = 1'b0;
              state_next    = BK_SEND;
            end
          endcase
        end
      end
      BK_READ: begin
        res_next   = '{found: 1'b1, value_byte: rd_data, byte_valid: 1'b1,
                       run_length: len, last_of_run: at_last};
        state_next = BK_SEND;
      end
      BK_SEND: begin
        if (tx.ready) begin
          if (is_value && !at_last) begin
            // fetch the next stored byte
            idx_next   = idx_inc;
            rd_en      = 1'b1;
            rd_addr    = idx_inc[AW-1:0];
            state_next = BK_READ;
          end else begin
            run_done   = is_value;
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      is_value <= 1'b0;
    end else begin
      state    <= state_next;
      is_value <= is_value_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    len <= len_next;
    res <= res_next;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the query key/value extractor: streams query strings,
// predicts each result word with its own scanner model and checks every field.
// Depends on qkv_pkg, qkv_if.sv and query_key_value_extractor.sv.
`timescale 1ns / 1ps

module tb;
  import qkv_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef logic [7:0] bytes_t[$];

  // Scanner model: tracks the key match and buffers the value for each accepted byte.
  class extract_scoreboard;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [5:0]  maxlen;
    phase_t      phase;
    logic [1:0]  pos;
    logic [7:0]  prev;
    logic [3:0]  trk_a;
    logic [3:0]  trk_b;
    logic [7:0]  store [32];
    logic [5:0]  count;
    res_t        pending_words[$];
    int          errors;
    int          words_checked;
    int          live_bytes;
    int          strings_done;
    int          found_runs;
    int          not_found_runs;

    function new();
      key = '0;
      klen = '0;
      maxlen = 6'd32;
      clear_run();
    endfunction

    function void clear_run();
      phase = PH_SEARCH;
      pos = 2'd0;
      prev = 8'h00;
      trk_a = 4'd0;
      trk_b = 4'd0;
      count = 6'd0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] d);
      case (idx)
        REG_KEY_BYTES:   key = d;
        REG_KEY_LENGTH:  klen = d[3:0];
        REG_MAX_VAL_LEN: maxlen = d[5:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] key_at(logic [3:0] i);
      return 8'(key >> (8 * i[2:0]));
    endfunction

    // length capped at eight and cut at the first zero byte
    function logic [3:0] key_len_eff();
      logic [3:0] n;
      n = (klen > 4'd8) ? 4'd8 : klen;
      for (int i = 0; i < n; i++)
        if (key_at(4'(i)) == 8'h00) return 4'(i);
      return n;
    endfunction

    function logic [3:0] advance(logic [3:0] code, logic [7:0] b, logic [3:0] n);
      logic [3:0] m;
      if (code == 4'd0) return 4'd0;
      m = code - 4'd1;
      if (m < n) return (b == key_at(m)) ? code + 4'd1 : 4'd0;
      if (m == n) return (b == CH_EQ) ? CONFIRMED : 4'd0;
      return 4'd0;
    endfunction

    function void push_miss();
      res_t w;
      w = '0;
      w.last_of_run = 1'b1;
      pending_words.push_back(w);
      phase = PH_DONE;
      not_found_runs++;
    endfunction

    function void push_value();
      res_t w;
      logic [5:0] cap;
      cap = (maxlen > COUNT_CAP) ? COUNT_CAP : maxlen;
      if (count >= cap) begin
        push_miss();
        return;
      end
      phase = PH_DONE;
      found_runs++;
      w = '0;
      w.found = 1'b1;
      if (count == 6'd0) begin
        w.last_of_run = 1'b1;
        pending_words.push_back(w);
        return;
      end
      for (int i = 0; i < count; i++) begin
        w.value_byte = store[i];
        w.byte_valid = 1'b1;
        w.run_length = count[4:0];
        w.last_of_run = (i == count - 1);
        pending_words.push_back(w);
      end
    endfunction

    function void scan_byte(logic [7:0] b, logic eos);
      logic term;
      logic hit;
      logic [3:0] n;
      logic [3:0] c;
      if (phase != PH_DONE) live_bytes++;
      term = (b == 8'h00 || b == CH_SPACE || b == CH_NL);
      hit = 1'b0;
      case (phase)
        PH_VALUE: begin
          if (term || b == CH_AMP) begin
            push_value();
          end else begin
            if (count < COUNT_CAP) begin
              store[count[4:0]] = b;
              count++;
            end
            if (eos) push_value();
          end
        end
        PH_SEARCH, PH_STOPPED: begin
          n = key_len_eff();
          trk_a = advance(trk_a, b, n);
          trk_b = advance(trk_b, b, n);
          hit = (trk_a == CONFIRMED || trk_b == CONFIRMED);
          if (!hit && phase == PH_SEARCH) begin
            if (term) begin
              phase = PH_STOPPED;
            end else if (pos == 2'd0 || prev == CH_AMP || (pos == 2'd1 && prev == CH_QMARK)) begin
              c = advance(4'd1, b, n);
              if (c == CONFIRMED) hit = 1'b1;
              // drop the start when both trackers are busy
              else if (c != 4'd0) begin
                if (trk_a == 4'd0) trk_a = c;
                else if (trk_b == 4'd0) trk_b = c;
              end
            end
          end
          if (hit) begin
            trk_a = 4'd0;
            trk_b = 4'd0;
            count = 6'd0;
            phase = PH_VALUE;
            if (eos) push_value();
          end else if (eos || (phase == PH_STOPPED && trk_a == 4'd0 && trk_b == 4'd0)) begin
            push_miss();
          end
        end
        default: ;
      endcase
      prev = b;
      if (pos < 2'd2) pos++;
      if (eos) begin
        clear_run();
        strings_done++;
      end
    endfunction

    function int field_diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_word(res_t got);
      res_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got found=%0d byte=%0d valid=%0d",
                 $time, got.found, got.value_byte, got.byte_valid);
        $display("%0t: unexpected word, got len=%0d last=%0d",
                 $time, got.run_length, got.last_of_run);
        return;
      end
      want = pending_words.pop_front();
      errors += field_diff("found", want.found, got.found);
      errors += field_diff("value_byte", want.value_byte, got.value_byte);
      errors += field_diff("byte_valid", want.byte_valid, got.byte_valid);
      errors += field_diff("run_length", want.run_length, got.run_length);
      errors += field_diff("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  qkv_in_if  rx_if();
  qkv_out_if tx_if();

  query_key_value_extractor u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx_if),
    .tx       (tx_if)
  );

  extract_scoreboard sb = new();

  int offered;
  int cfg_round;
  bit hold_now;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // check result words first, then feed the accepted byte to the model
  always @(posedge clk) begin
    if (!rst) begin
      if (tx_if.valid && tx_if.ready)
        sb.check_word('{found: tx_if.found, value_byte: tx_if.value_byte,
                        byte_valid: tx_if.byte_valid, run_length: tx_if.run_length,
                        last_of_run: tx_if.last_of_run});
      if (rx_if.valid && rx_if.ready) sb.scan_byte(rx_if.data_byte, rx_if.end_of_source);
    end
  end

  // result side: random stalls, a calm window, and one long hold-off
  initial begin
    tx_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now && !hold_done) begin
        hold_done = 1'b1;
        tx_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      tx_if.ready <= (offered >= 100 && offered < 200) ||
                     ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d words still expected", sb.pending_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 2))
      0: return 8'h61;
      1: return 8'h62;
      default: return 8'h6B;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!(offered >= 200 && offered < 300) && $urandom_range(0, 99) < 15) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.data_byte <= b;
    rx_if.end_of_source <= eos;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    offered++;
  endtask

  task automatic send_string(input bytes_t s);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
  endtask

  // wait until the last accepted byte has reached the model
  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic load_config(input logic [63:0] k, input logic [3:0] kl, input logic [5:0] ml);
    logic [63:0] junk;
    drain();
    junk = {$urandom, $urandom};
    write_reg(REG_UNUSED, junk);
    write_reg(REG_KEY_BYTES, k);
    write_reg(REG_KEY_LENGTH, (junk & ~64'hF) | 64'(kl));
    write_reg(REG_MAX_VAL_LEN, (~junk & ~64'h3F) | 64'(ml));
    cfg_en <= 1'b0;
    cfg_round++;
  endtask

  initial begin
    bytes_t s;
    logic [63:0] k;
    logic [3:0] kl;
    logic [5:0] ml;
    logic [5:0] lim_list [7];
    int lim_idx;
    int pick;
    int nl;
    int vlen;
    int nparams;

    lim_list = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};
    lim_idx = 0;
    rst <= 1'b1;
    cfg_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rx_if.valid <= 1'b0;
    rx_if.data_byte <= '0;
    rx_if.end_of_source <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty key matches a parameter that starts with '='
    load_config(64'd0, 4'd0, 6'd32);
    s = {CH_EQ, 8'h78};
    send_string(s);
    // key "ab": empty value on the last byte, then an empty value closed by '&'
    load_config(64'h6261, 4'd2, 6'd32);
    s = {CH_QMARK, 8'h61, 8'h62, CH_EQ};
    send_string(s);
    s = {8'h61, 8'h62, CH_EQ, CH_AMP};
    send_string(s);
    // no match, null terminator
    s = {8'hFF, 8'h00};
    send_string(s);
    // length limit: one byte too long, and a zero limit that never finds
    load_config(64'h6261, 4'd2, 6'd1);
    s = {8'h61, 8'h62, CH_EQ, 8'h63};
    send_string(s);
    load_config(64'h6261, 4'd2, 6'd0);
    s = {8'h61, 8'h62, CH_EQ};
    send_string(s);

    while (offered < 340) begin
      k = '0;
      case (cfg_round % 6)
        0: begin
          kl = 4'($urandom_range(1, 8));
          for (int i = 0; i < 8; i++) k[8*i +: 8] = pick_char();
          ml = 6'd32;
        end
        1: begin
          kl = 4'($urandom_range(1, 3));
          for (int i = 0; i < 8; i++) k[8*i +: 8] = pick_char();
          ml = lim_list[lim_idx % 7];
          lim_idx++;
        end
        2: begin
          kl = 4'($urandom_range(1, 4));
          for (int i = 0; i < 8; i++)
            case ($urandom_range(0, 4))
              0: k[8*i +: 8] = CH_AMP;
              1: k[8*i +: 8] = CH_SPACE;
              2: k[8*i +: 8] = CH_NL;
              3: k[8*i +: 8] = CH_EQ;
              default: k[8*i +: 8] = 8'h61;
            endcase
          ml = 6'($urandom_range(20, 63));
        end
        3: begin
          kl = 4'($urandom_range(9, 15));
          for (int i = 0; i < 8; i++) k[8*i +: 8] = pick_char();
          ml = 6'd63;
        end
        4: begin
          kl = 4'd8;
          for (int i = 0; i < 8; i++) k[8*i +: 8] = pick_char();
          k[8*$urandom_range(1, 6) +: 8] = 8'h00;
          ml = 6'd32;
        end
        default: begin
          kl = 4'($urandom_range(0, 1));
          k = '1;
          ml = 6'($urandom_range(1, 63));
        end
      endcase
      load_config(k, kl, ml);
      // hold the result side while a whole phase streams in
      if (cfg_round == 5) hold_now = 1'b1;

      repeat (3) begin
        s = {};
        nparams = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) s.push_back(CH_QMARK);
        for (int p = 0; p < nparams; p++) begin
          if (p > 0) s.push_back(CH_AMP);
          pick = $urandom_range(0, 5);
          nl = (sb.klen > 4'd8) ? 8 : int'(sb.klen);
          if (pick == 3 && nl > 0) nl = $urandom_range(0, nl - 1);
          if (pick == 5) begin
            repeat ($urandom_range(1, 3)) s.push_back(pick_char());
          end else begin
            for (int j = 0; j < nl; j++) s.push_back(sb.key_at(4'(j)));
            if (pick == 4) s.push_back(pick_char());
          end
          if ($urandom_range(0, 7) != 0) s.push_back(CH_EQ);
          vlen = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 6);
          repeat (vlen) begin
            if ($urandom_range(0, 11) == 0) s.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 5) == 0) s.push_back(8'h39);
            else s.push_back(pick_char());
          end
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 2))
            0: s.push_back(8'h00);
            1: s.push_back(CH_SPACE);
            default: s.push_back(CH_NL);
          endcase
          repeat ($urandom_range(0, 3)) s.push_back(pick_char());
        end else if (pick == 1) begin
          repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(0, 255)));
        end
        if (s.size() == 0) s.push_back(pick_char());
        send_string(s);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Scanned %0d live bytes in %0d strings under %0d register settings.",
             sb.live_bytes, sb.strings_done, cfg_round);
    $display("Saw %0d value answers and %0d not-found answers over %0d result words.",
             sb.found_runs, sb.not_found_runs, sb.words_checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
